[design/ebml_element_header_parser_defines.svh]
// Assertion macros used by the checker file.
`ifndef EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH
`define EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebml header parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebml header parser: next-cycle check failed");

`endif

[design/ebml_hdr_pkg.sv]
package ebml_hdr_pkg;

    typedef enum logic [1:0] {
        PH_ID_FIRST,
        PH_ID_MORE,
        PH_SIZE_FIRST,
        PH_SIZE_MORE
    } phase_t;

    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_ALL_ONES = 2'd1;
    localparam logic [1:0] FAULT_ZERO     = 2'd2;
    localparam logic [1:0] FAULT_TOO_LONG = 2'd3;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_MSB      = 8'h80;

    localparam logic REG_MAX_ID   = 1'b0;
    localparam logic REG_MAX_SIZE = 1'b1;

    localparam logic [3:0] MAX_BYTES_RESET = 4'd4;

    typedef struct packed {
        logic [3:0] max_id_bytes;
        logic [3:0] max_size_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  fault;
        logic [3:0]  size_bytes;
        logic [55:0] data_size;
        logic [3:0]  id_bytes;
        logic [63:0] element_id;
    } result_t;

    // Field length = 1 + leading zeros of the first byte; 0 for a zero byte.
    function automatic logic [3:0] vint_len(input logic [7:0] b);
        logic [3:0] len;
        len = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (((b & (BYTE_MSB >> i)) != BYTE_ZERO) && (len == 4'd0))
                len = 4'(i + 1);
        end
        return len;
    endfunction

endpackage

[design/ebml_hdr_cfg.sv]
module ebml_hdr_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data,
    output ebml_hdr_pkg::cfg_t cfg
);

    logic [3:0] max_id_reg;
    logic [3:0] max_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_id_reg   <= ebml_hdr_pkg::MAX_BYTES_RESET;
            max_size_reg <= ebml_hdr_pkg::MAX_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ebml_hdr_pkg::REG_MAX_ID:   max_id_reg   <= cfg_data;
                ebml_hdr_pkg::REG_MAX_SIZE: max_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.max_id_bytes   = max_id_reg;
    assign cfg.max_size_bytes = max_size_reg;

endmodule

[design/ebml_hdr_core.sv]
module ebml_hdr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ebml_hdr_pkg::cfg_t    cfg,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    output logic                  emit,
    output ebml_hdr_pkg::result_t result
);

    ebml_hdr_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] held_id_reg, held_id_next;
    logic [3:0]  held_id_bytes_reg, held_id_bytes_next;
    logic [3:0]  held_size_bytes_reg, held_size_bytes_next;

    logic        is_first;
    logic [3:0]  len;
    logic [3:0]  limit;
    logic [1:0]  fault;
    logic [2:0]  first_left;
    logic [2:0]  left_dec;
    logic [63:0] acc_shift;
    logic [7:0]  size_first;

    // shared decode of the current byte
    always_comb
    begin
        is_first   = (phase_reg == ebml_hdr_pkg::PH_ID_FIRST) ||
                     (phase_reg == ebml_hdr_pkg::PH_SIZE_FIRST);
        len        = ebml_hdr_pkg::vint_len(byte_in);
        limit      = (phase_reg == ebml_hdr_pkg::PH_SIZE_FIRST) ?
                     cfg.max_size_bytes : cfg.max_id_bytes;
        first_left = 3'(len - 4'd1);
        left_dec   = bytes_left_reg - 3'd1;
        acc_shift  = {acc_reg[55:0], byte_in};
        // marker bit and the zeros before it dropped; nothing left at length 8
        size_first = byte_in & (ebml_hdr_pkg::BYTE_ALL_ONES >> len);
        fault      = ebml_hdr_pkg::FAULT_OK;
        if (is_first)
        begin
            priority if (byte_in == ebml_hdr_pkg::BYTE_ALL_ONES)
                fault = ebml_hdr_pkg::FAULT_ALL_ONES;
            else if (byte_in == ebml_hdr_pkg::BYTE_ZERO)
                fault = ebml_hdr_pkg::FAULT_ZERO;
            else if (len > limit)
                fault = ebml_hdr_pkg::FAULT_TOO_LONG;
            else
                fault = ebml_hdr_pkg::FAULT_OK;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            ebml_hdr_pkg::PH_ID_FIRST:
            begin
                if (fault != ebml_hdr_pkg::FAULT_OK)
                    phase_next = ebml_hdr_pkg::PH_ID_FIRST;
                else if (first_left == 3'd0)
                    phase_next = ebml_hdr_pkg::PH_SIZE_FIRST;
                else
                    phase_next = ebml_hdr_pkg::PH_ID_MORE;
            end
            ebml_hdr_pkg::PH_ID_MORE:
            begin
                if (left_dec == 3'd0)
                    phase_next = ebml_hdr_pkg::PH_SIZE_FIRST;
            end
            ebml_hdr_pkg::PH_SIZE_FIRST:
            begin
                if (fault != ebml_hdr_pkg::FAULT_OK || first_left == 3'd0)
                    phase_next = ebml_hdr_pkg::PH_ID_FIRST;
                else
                    phase_next = ebml_hdr_pkg::PH_SIZE_MORE;
            end
            ebml_hdr_pkg::PH_SIZE_MORE:
            begin
                if (left_dec == 3'd0)
                    phase_next = ebml_hdr_pkg::PH_ID_FIRST;
            end
            default: phase_next = ebml_hdr_pkg::PH_ID_FIRST;
        endcase
    end

    // datapath and result
    always_comb
    begin
        bytes_left_next      = bytes_left_reg;
        acc_next             = acc_reg;
        held_id_next         = held_id_reg;
        held_id_bytes_next   = held_id_bytes_reg;
        held_size_bytes_next = held_size_bytes_reg;
        emit                 = 1'b0;
        result               = '0;
        unique case (phase_reg)
            ebml_hdr_pkg::PH_ID_FIRST, ebml_hdr_pkg::PH_SIZE_FIRST:
            begin
                if (fault != ebml_hdr_pkg::FAULT_OK)
                begin
                    emit            = 1'b1;
                    result.fault    = fault;
                    bytes_left_next = 3'd0;
                    acc_next        = '0;
                end
                else if (phase_reg == ebml_hdr_pkg::PH_ID_FIRST)
                begin
                    bytes_left_next    = first_left;
                    held_id_bytes_next = len;
                    if (first_left == 3'd0)
                    begin
                        held_id_next = 64'(byte_in);
                        acc_next     = '0;
                    end
                    else
                        acc_next = 64'(byte_in);
                end
                else
                begin
                    bytes_left_next      = first_left;
                    held_size_bytes_next = len;
                    if (first_left == 3'd0)
                    begin
                        emit              = 1'b1;
                        result.element_id = held_id_reg;
                        result.id_bytes   = held_id_bytes_reg;
                        result.data_size  = 56'(size_first);
                        result.size_bytes = len;
                        acc_next          = '0;
                    end
                    else
                        acc_next = 64'(size_first);
                end
            end
            ebml_hdr_pkg::PH_ID_MORE, ebml_hdr_pkg::PH_SIZE_MORE:
            begin
                bytes_left_next = left_dec;
                acc_next        = acc_shift;
                if (left_dec == 3'd0)
                begin
                    acc_next = '0;
                    if (phase_reg == ebml_hdr_pkg::PH_ID_MORE)
                        held_id_next = acc_shift;
                    else
                    begin
                        emit              = 1'b1;
                        result.element_id = held_id_reg;
                        result.id_bytes   = held_id_bytes_reg;
                        result.data_size  = acc_shift[55:0];
                        result.size_bytes = held_size_bytes_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= ebml_hdr_pkg::PH_ID_FIRST;
            bytes_left_reg      <= '0;
            acc_reg             <= '0;
            held_id_reg         <= '0;
            held_id_bytes_reg   <= '0;
            held_size_bytes_reg <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            bytes_left_reg      <= bytes_left_next;
            acc_reg             <= acc_next;
            held_id_reg         <= held_id_next;
            held_id_bytes_reg   <= held_id_bytes_next;
            held_size_bytes_reg <= held_size_bytes_next;
        end
    end

endmodule

[design/ebml_element_header_parser.sv]
// The header's last byte goes through the input register, then the output register.
// Throughput: one byte per cycle unless a held result stalls the parser.
// The input register keeps taking bytes while a result waits, until it holds one itself.
// Reset (rst_n low, asynchronous): parser back to the ID's first byte, both length
// limits back to 4, input and output registers empty.
module ebml_element_header_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] element_id, [67:64] id_bytes, [123:68] data_size, [127:124] size_bytes
    output logic [127:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // [1:0] fault
);

    ebml_hdr_pkg::cfg_t    cfg;
    ebml_hdr_pkg::result_t result;
    ebml_hdr_pkg::result_t out_reg;
    logic                  emit;
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  fire;
    logic                  s_xfer;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = s_xfer ? 1'b1 : (in_valid_reg && !fire);
        out_valid_next = fire ? emit : (out_valid_reg && !m_axis_tready);
    end

    ebml_hdr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ebml_hdr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (fire),
        .byte_in (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_byte_reg <= s_axis_tdata;
        if (fire && emit)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.size_bytes, out_reg.data_size,
                            out_reg.id_bytes, out_reg.element_id};
    assign m_axis_tuser  = out_reg.fault;

endmodule

[design/ebml_hdr_checker.sv]
`include "ebml_element_header_parser_defines.svh"

module ebml_hdr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a held result keeps its value until the transfer
    `EHP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // faulted results carry all-zero fields
    `EHP_ASSERT_NOW(a_fault_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != ebml_hdr_pkg::FAULT_OK),
        m_axis_tdata == 128'd0)

    // a good header has both lengths within one to eight bytes
    `EHP_ASSERT_NOW(a_ok_lengths, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ebml_hdr_pkg::FAULT_OK),
        (m_axis_tdata[67:64] != 4'd0) && (m_axis_tdata[67:64] <= 4'd8) &&
        (m_axis_tdata[127:124] != 4'd0) && (m_axis_tdata[127:124] <= 4'd8))

    // the input side only stalls behind a stalled result
    `EHP_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready)

endmodule

bind ebml_element_header_parser ebml_hdr_checker u_ebml_hdr_checker (.*);

[test/ebml_element_header_parser_tb.sv]
module ebml_element_header_parser_tb;

    localparam int SEG_BYTES   = 236;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic [3:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] byte_in
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [63:0] element_id, [67:64] id_bytes, [123:68] data_size, [127:124] size_bytes
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;   // [1:0] fault

    int src_idle;
    int dst_idle;
    int cycles;
    int sent;
    logic [3:0] cur_id_lim;
    logic [3:0] cur_size_lim;

    // Header predictor plus queue of expected headers
    class header_scoreboard;
        ebml_hdr_pkg::phase_t  ph;
        logic [2:0]            left;
        logic [63:0]           acc;
        logic [63:0]           id_hold;
        logic [3:0]            id_n;
        logic [3:0]            size_n;
        logic [3:0]            lim_id;
        logic [3:0]            lim_size;
        ebml_hdr_pkg::result_t expected_q[$];
        int                    errors;

        function new();
            ph       = ebml_hdr_pkg::PH_ID_FIRST;
            left     = '0;
            acc      = '0;
            id_hold  = '0;
            id_n     = '0;
            size_n   = '0;
            lim_id   = ebml_hdr_pkg::MAX_BYTES_RESET;
            lim_size = ebml_hdr_pkg::MAX_BYTES_RESET;
            errors   = 0;
        endfunction

        function void set_limits(logic [3:0] id_lim, logic [3:0] size_lim);
            lim_id   = id_lim;
            lim_size = size_lim;
        endfunction

        function logic [3:0] field_len(logic [7:0] b);
            for (int i = 7; i >= 0; i--)
                if (b[i])
                    return 4'(8 - i);
            return 4'd0;
        endfunction

        function void restart();
            ph   = ebml_hdr_pkg::PH_ID_FIRST;
            left = '0;
            acc  = '0;
        endfunction

        function void push_fault(logic [1:0] code);
            ebml_hdr_pkg::result_t r;
            r = '0;
            r.fault = code;
            expected_q = {expected_q, r};
            restart();
        endfunction

        function void push_header();
            ebml_hdr_pkg::result_t r;
            r.element_id = id_hold;
            r.id_bytes   = id_n;
            r.data_size  = acc[55:0];
            r.size_bytes = size_n;
            r.fault      = ebml_hdr_pkg::FAULT_OK;
            expected_q = {expected_q, r};
            restart();
        endfunction

        function void note_byte(logic [7:0] b);
            logic [3:0] len;
            logic       is_size;
            if (ph == ebml_hdr_pkg::PH_ID_FIRST || ph == ebml_hdr_pkg::PH_SIZE_FIRST)
            begin
                is_size = (ph == ebml_hdr_pkg::PH_SIZE_FIRST);
                if (b == ebml_hdr_pkg::BYTE_ALL_ONES)
                begin
                    push_fault(ebml_hdr_pkg::FAULT_ALL_ONES);
                    return;
                end
                if (b == ebml_hdr_pkg::BYTE_ZERO)
                begin
                    push_fault(ebml_hdr_pkg::FAULT_ZERO);
                    return;
                end
                len = field_len(b);
                if (len > (is_size ? lim_size : lim_id))
                begin
                    push_fault(ebml_hdr_pkg::FAULT_TOO_LONG);
                    return;
                end
                left = 3'(len - 4'd1);
                if (is_size)
                begin
                    // drop marker and the zeros ahead of it
                    acc    = 64'(b & (8'hFF >> len));
                    size_n = len;
                    if (left == 3'd0)
                        push_header();
                    else
                        ph = ebml_hdr_pkg::PH_SIZE_MORE;
                end
                else
                begin
                    acc  = 64'(b);
                    id_n = len;
                    if (left == 3'd0)
                    begin
                        id_hold = acc;
                        acc     = '0;
                        ph      = ebml_hdr_pkg::PH_SIZE_FIRST;
                    end
                    else
                    begin
                        ph = ebml_hdr_pkg::PH_ID_MORE;
                    end
                end
                return;
            end
            acc  = {acc[55:0], b};
            left = left - 3'd1;
            if (left != 3'd0)
                return;
            if (ph == ebml_hdr_pkg::PH_ID_MORE)
            begin
                id_hold = acc;
                acc     = '0;
                ph      = ebml_hdr_pkg::PH_SIZE_FIRST;
            end
            else
            begin
                push_header();
            end
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s expected %h actual %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_header(logic [127:0] data, logic [1:0] user);
            ebml_hdr_pkg::result_t e;
            if (expected_q.size() == 0)
            begin
                $error("header transfer with none expected: tdata %h tuser %h", data, user);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("element_id", e.element_id, data[63:0]);
            cmp("id_bytes", 64'(e.id_bytes), 64'(data[67:64]));
            cmp("data_size", 64'(e.data_size), 64'(data[123:68]));
            cmp("size_bytes", 64'(e.size_bytes), 64'(data[127:124]));
            cmp("fault", 64'(e.fault), 64'(user));
        endfunction
    endclass

    header_scoreboard sb;

    ebml_element_header_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_header(m_axis_tdata, m_axis_tuser);

    // entered right after a falling edge, returns right after one
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(b);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_limits(input logic [3:0] id_lim, input logic [3:0] size_lim);
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        // a partial header may still be in the pipe
        repeat (8) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = ebml_hdr_pkg::REG_MAX_ID;
        cfg_data  = id_lim;
        @(negedge clk);
        cfg_index = ebml_hdr_pkg::REG_MAX_SIZE;
        cfg_data  = size_lim;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_limits(id_lim, size_lim);
        cur_id_lim   = id_lim;
        cur_size_lim = size_lim;
    endtask

    function automatic int pick_len(logic [3:0] lim);
        int top;
        top = (lim == 4'd0) ? 1 : ((lim > 4'd8) ? 8 : int'(lim));
        if ($urandom_range(99) < 12)
            return $urandom_range(1, 8);
        if (top > 4 && $urandom_range(99) < 70)
            return $urandom_range(1, 4);
        return $urandom_range(1, top);
    endfunction

    task automatic send_field(input int len);
        logic [7:0] marker;
        marker = ebml_hdr_pkg::BYTE_MSB >> (len - 1);
        send_byte(marker | (8'($urandom) & (marker - 8'd1)));
        repeat (len - 1) send_byte(8'($urandom));
    endtask

    task automatic run_segment(input int n);
        int r;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(99);
            if (r < 85)
            begin
                send_field(pick_len(cur_id_lim));
                send_field(pick_len(cur_size_lim));
            end
            else if (r < 90)
            begin
                send_byte(ebml_hdr_pkg::BYTE_ALL_ONES);
            end
            else if (r < 95)
            begin
                send_byte(ebml_hdr_pkg::BYTE_ZERO);
            end
            else
            begin
                send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [3:0] seg_id[7];
        logic [3:0] seg_size[7];
        seg_id   = '{4'd4, 4'd8, 4'd1, 4'd15, 4'd0, 4'd2, 4'd8};
        seg_size = '{4'd4, 4'd8, 4'd2, 4'd0, 4'd15, 4'd8, 4'd1};
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ebml_hdr_pkg::REG_MAX_ID;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        sent          = 0;
        src_idle      = 38;
        dst_idle      = 50;
        cur_id_lim    = ebml_hdr_pkg::MAX_BYTES_RESET;
        cur_size_lim  = ebml_hdr_pkg::MAX_BYTES_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, limits at reset value 4
        send_byte(8'h80); send_byte(8'h80);          // shortest header, zero size
        send_byte(ebml_hdr_pkg::BYTE_ALL_ONES);      // ID first byte all ones
        send_byte(ebml_hdr_pkg::BYTE_ZERO);          // ID first byte zero
        send_byte(8'h81);
        send_byte(ebml_hdr_pkg::BYTE_ALL_ONES);      // unknown size not supported
        send_byte(8'h81);
        send_byte(ebml_hdr_pkg::BYTE_ZERO);          // size first byte zero
        send_byte(8'h08);                            // 5-byte ID over limit
        send_byte(8'hC0); send_byte(8'h08);          // 5-byte size over limit

        // 8-byte ID and 8-byte size, first size byte adds nothing
        write_limits(4'd8, 4'd8);
        send_byte(8'h01);
        repeat (7) send_byte(ebml_hdr_pkg::BYTE_ALL_ONES);
        send_byte(8'h01);
        repeat (7) send_byte(8'hA5);

        for (int s = 0; s < 7; s++)
        begin
            write_limits(seg_id[s], seg_size[s]);
            if (s < 3)
            begin
                src_idle = 38;
                dst_idle = 50;
            end
            else if (s < 5)
            begin
                src_idle = 50;
                dst_idle = 38;
            end
            else
            begin
                src_idle = 0;
                dst_idle = 0;
            end
            run_segment(SEG_BYTES);
        end

        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/ebml_hdr_pkg.sv
design/ebml_hdr_cfg.sv
design/ebml_hdr_core.sv
design/ebml_element_header_parser.sv
design/ebml_hdr_checker.sv
test/ebml_element_header_parser_tb.sv
